FILE: hdl/sfr_pkg.sv
package sfr_pkg;

  // Receive buffer size; the payload limit leaves room for header and trailer
  localparam int unsigned BufferBytes = 256;
  localparam logic [15:0] LenLimit    = 16'(BufferBytes - 8);

  localparam logic [31:0] CrcPoly = 32'h04C1_1DB7;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  localparam logic [7:0]  StartByteRst  = 8'h5F;
  localparam logic [15:0] MaxPayloadRst = 16'd248;

  // Configuration register indexes
  localparam logic CfgStartByte  = 1'b0;
  localparam logic CfgMaxPayload = 1'b1;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_LEN_ERR = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] payload_length;
    logic [7:0]  command;
    logic [31:0] received_crc;
    logic [31:0] computed_crc;
  } result_t;

  // CRC-32/MPEG-2 update by one byte, MSB first
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  din);
    logic [31:0] c;
    c = crc_in ^ {din, 24'h0};
    for (int i = 0; i < 8; i++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hdl/sfr_parser.sv
module sfr_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [7:0]      rx_byte,
  input  logic [7:0]      start_byte,
  input  logic [15:0]     max_payload,
  output logic            res_valid,
  output sfr_pkg::result_t res
);
  import sfr_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD,
    PH_TRAILER
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic [15:0] limit;
  logic [15:0] pos_inc;

  assign limit   = (max_payload < LenLimit) ? max_payload : LenLimit;
  assign pos_inc = pos_r + 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    cmd_nxt   = cmd_r;
    crc_nxt   = crc_r;
    shift_nxt = shift_r;
    pad_nxt   = pad_r;
    res_valid = 1'b0;
    res       = '0;
    unique case (phase_r)
      PH_HUNT: begin
        if (rx_byte == start_byte) begin
          crc_nxt   = crc32_byte(CrcInit, rx_byte);
          len_nxt   = '0;
          cmd_nxt   = '0;
          shift_nxt = '0;
          pad_nxt   = '0;
          pos_nxt   = 16'd1;
          phase_nxt = PH_HEADER;
        end
      end
      PH_HEADER: begin
        crc_nxt = crc32_byte(crc_r, rx_byte);
        if (pos_r == 16'd1) begin
          len_nxt = {rx_byte, 8'h00};
          pos_nxt = 16'd2;
        end else if (pos_r == 16'd2) begin
          len_nxt = {len_r[15:8], rx_byte};
          pos_nxt = 16'd3;
          if (len_nxt > limit) begin
            res_valid          = 1'b1;
            res.status         = ST_LEN_ERR;
            res.payload_length = len_nxt;
            phase_nxt          = PH_HUNT;
            pos_nxt            = '0;
            shift_nxt          = '0;
            pad_nxt            = '0;
          end
        end else begin
          cmd_nxt   = rx_byte;
          pad_nxt   = 2'd0 - len_r[1:0];
          pos_nxt   = '0;
          phase_nxt = (len_r == 16'd0) ? PH_TRAILER : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        crc_nxt = crc32_byte(crc_r, rx_byte);
        if (pos_inc >= len_r) begin
          pos_nxt   = '0;
          phase_nxt = PH_TRAILER;
        end else begin
          pos_nxt = pos_inc;
        end
      end
      PH_TRAILER: begin
        shift_nxt = {shift_r[23:0], rx_byte};
        pos_nxt   = pos_inc;
        // feed one zero pad byte per trailer byte until aligned
        if (pad_r != 2'd0) begin
          crc_nxt = crc32_byte(crc_r, 8'h00);
          pad_nxt = pad_r - 2'd1;
        end
        if (pos_inc >= 16'd4) begin
          res_valid          = 1'b1;
          res.status         = (crc_nxt == shift_nxt) ? ST_GOOD : ST_CRC_ERR;
          res.payload_length = len_r;
          res.command        = cmd_r;
          res.received_crc   = shift_nxt;
          res.computed_crc   = crc_nxt;
          phase_nxt          = PH_HUNT;
          pos_nxt            = '0;
          shift_nxt          = '0;
          pad_nxt            = '0;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
    if (!step) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pos_r   <= '0;
      len_r   <= '0;
      cmd_r   <= '0;
      crc_r   <= CrcInit;
      shift_r <= '0;
      pad_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      cmd_r   <= cmd_nxt;
      crc_r   <= crc_nxt;
      shift_r <= shift_nxt;
      pad_r   <= pad_nxt;
    end
  end

endmodule

FILE: hdl/sfr_out_fifo.sv
module sfr_out_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sfr_pkg::result_t push_data,
  output logic             space,
  output logic             pop_valid,
  input  logic             pop_ready,
  output sfr_pkg::result_t pop_data
);
  import sfr_pkg::*;

  result_t    ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign space     = (cnt_r != 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_data  = ent_r[rd_ptr_r];
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

FILE: hdl/sof_length_crc32_frame_receiver.sv
// Frame receiver for a byte stream: hunt for the start byte, read a big-endian
// 16-bit payload length, one command byte, the payload and a big-endian
// CRC-32/MPEG-2 trailer. The CRC covers the four header bytes and the payload,
// zero-padded to a multiple of four bytes; the pad bytes are folded in while
// the trailer arrives. One status transaction leaves per frame: good or CRC
// mismatch after the last trailer byte, or a length error right after the
// second length byte when the length exceeds min(max_payload, 248), after
// which the receiver hunts again. A start byte inside a frame is plain data.
// Rate: one byte per clock unless the output queue is full. In the input
// register the byte-wide CRC update and frame state advance in a single pass;
// a status is then written into a two-entry output queue, which keeps input
// flowing while a status waits for out_tready on the out_ side. The user must
// write configuration (cfg_we/cfg_index/cfg_wdata) only while the receiver is
// idle, unchecked by the block: index 0 start byte, index 1 max payload length.
module sof_length_crc32_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  // input byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // status stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [15:0] payload_length, [23:16] command,
                                  // [55:24] received_crc, [87:56] computed_crc
  output logic [1:0]  out_tuser,  // [1:0] status
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import sfr_pkg::*;

  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic [7:0]  start_byte_r;
  logic [15:0] max_payload_r;
  logic        advance;
  logic        fifo_space;
  logic        res_valid;
  result_t     res;
  result_t     out_res;

  // advance the parser when the queue can take a possible status
  assign advance   = in_vld_r && fifo_space;
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  // hold the byte until the parser takes it
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r  <= StartByteRst;
      max_payload_r <= MaxPayloadRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgStartByte:  start_byte_r  <= cfg_wdata[7:0];
        CfgMaxPayload: max_payload_r <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  sfr_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .rx_byte     (in_byte_r),
    .start_byte  (start_byte_r),
    .max_payload (max_payload_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  sfr_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .space     (fifo_space),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (out_res)
  );

  assign out_tdata = {out_res.computed_crc, out_res.received_crc,
                      out_res.command, out_res.payload_length};
  assign out_tuser = out_res.status;

endmodule

FILE: sim/sof_length_crc32_frame_receiver_tb.sv
module sof_length_crc32_frame_receiver_tb;
  import sfr_pkg::*;

  // The receive buffer must keep room for the header and the trailer, so the
  // accepted payload length never exceeds this, whatever max_payload says.
  localparam int unsigned RX_BUF_BYTES = 256;
  localparam logic [15:0] BUF_LEN_CAP  = 16'(RX_BUF_BYTES - 8);

  localparam logic [31:0] CRC_POLY_MSB = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_SEED     = 32'hFFFF_FFFF;

  localparam int WATCHDOG_CYCLES = 2000;  // cycles without any transaction
  localparam int HOLD_CYCLES     = 400;   // long receiver hold-off
  localparam int SETTLE_CYCLES   = 8;     // input register + output queue
  localparam int PHASE_BYTES     = 100;   // random bytes per configuration phase
  localparam int NUM_PHASES      = 10;
  localparam int DIR_ROWS        = 25;

  typedef enum logic [1:0] {
    RX_HUNT,
    RX_HEADER,
    RX_PAYLOAD,
    RX_TRAILER
  } rx_phase_t;

  typedef struct {
    logic [7:0] rx_byte;
    bit         typed;    // expected status written out in the row
    result_t    exp_res;
  } dir_row_t;

  localparam result_t NO_RES = '0;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;   // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;            // [15:0] payload_length, [23:16] command,
                                     // [55:24] received_crc, [87:56] computed_crc
  logic [1:0]  out_tuser;            // [1:0] status
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = CfgStartByte;
  logic [15:0] cfg_wdata  = 16'h0000;

  // Mirror of the configuration registers
  logic [7:0]  cur_start   = StartByteRst;
  logic [15:0] cur_max_len = MaxPayloadRst;

  // Frame state as the predictor tracks it
  rx_phase_t   fr_phase = RX_HUNT;
  logic [15:0] fr_pos   = '0;
  logic [15:0] fr_len   = '0;
  logic [7:0]  fr_cmd   = '0;
  logic [31:0] fr_crc   = CRC_SEED;
  logic [31:0] fr_trl   = '0;
  logic [1:0]  fr_pad   = '0;

  result_t     pending_status [$];
  result_t     want_res;
  int          fail_cnt  = 0;
  int          sent_cnt  = 0;
  int          idle_cnt  = 0;
  bit          tx_burst  = 1'b0;   // sender offers back to back
  bit          rx_burst  = 1'b0;   // receiver always ready
  bit          hold_req  = 1'b0;   // ask the receiver for one long hold-off

  // Directed bytes, sent with the reset configuration (start 0x5F, limit 248).
  // Length errors are written out; the two short frames go to the predictor.
  dir_row_t dir_tbl [DIR_ROWS] = '{
    // non-start bytes while hunting: dropped
    '{8'h00, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    // length one above the limit: error right after the second length byte
    '{8'h5F, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'hF9, 1'b1, '{ST_LEN_ERR, 16'd249, 8'h00, 32'h0, 32'h0}},
    // largest possible length
    '{8'h5F, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'hFF, 1'b1, '{ST_LEN_ERR, 16'hFFFF, 8'h00, 32'h0, 32'h0}},
    // empty payload: trailer right after the command byte, CRC mismatch
    '{8'h5F, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'hA5, 1'b0, NO_RES},
    '{8'hDE, 1'b0, NO_RES},
    '{8'hAD, 1'b0, NO_RES},
    '{8'hBE, 1'b0, NO_RES},
    '{8'hEF, 1'b0, NO_RES},
    // one payload byte equal to the start byte: plain data, three pad bytes
    '{8'h5F, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h01, 1'b0, NO_RES},
    '{8'hC3, 1'b0, NO_RES},
    '{8'h5F, 1'b0, NO_RES},
    '{8'h01, 1'b0, NO_RES},
    '{8'h02, 1'b0, NO_RES},
    '{8'h03, 1'b0, NO_RES},
    '{8'h04, 1'b0, NO_RES}
  };

  sof_length_crc32_frame_receiver u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // CRC-32/MPEG-2, one data bit at a time from the MSB
  function automatic logic [31:0] crc_next(input logic [31:0] crc, input logic [7:0] d);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[31] ^ d[i];
      c  = {c[30:0], 1'b0} ^ (fb ? CRC_POLY_MSB : 32'h0);
    end
    return c;
  endfunction

  // Advance the frame state by one received byte; return 1 when a status
  // transaction is due and fill res with it.
  function automatic bit rx_frame_predict(input logic [7:0] b, output result_t res);
    logic [15:0] lim;
    res = '0;
    case (fr_phase)
      RX_HUNT: begin
        if (b == cur_start) begin
          fr_crc   = crc_next(CRC_SEED, b);
          fr_len   = '0;
          fr_cmd   = '0;
          fr_trl   = '0;
          fr_pad   = '0;
          fr_pos   = 16'd1;
          fr_phase = RX_HEADER;
        end
        return 1'b0;
      end
      RX_HEADER: begin
        fr_crc = crc_next(fr_crc, b);
        if (fr_pos == 16'd1) begin
          fr_len = {b, 8'h00};
          fr_pos = 16'd2;
          return 1'b0;
        end
        if (fr_pos == 16'd2) begin
          fr_len[7:0] = b;
          fr_pos      = 16'd3;
          lim         = (cur_max_len < BUF_LEN_CAP) ? cur_max_len : BUF_LEN_CAP;
          if (fr_len > lim) begin
            res.status         = ST_LEN_ERR;
            res.payload_length = fr_len;
            fr_phase = RX_HUNT;
            fr_pos   = '0;
            fr_trl   = '0;
            fr_pad   = '0;
            return 1'b1;
          end
          return 1'b0;
        end
        fr_cmd   = b;
        fr_pad   = 2'(-fr_len);
        fr_pos   = '0;
        fr_phase = (fr_len == 16'd0) ? RX_TRAILER : RX_PAYLOAD;
        return 1'b0;
      end
      RX_PAYLOAD: begin
        fr_crc = crc_next(fr_crc, b);
        fr_pos = fr_pos + 16'd1;
        if (fr_pos >= fr_len) begin
          fr_pos   = '0;
          fr_phase = RX_TRAILER;
        end
        return 1'b0;
      end
      default: begin
        fr_trl = {fr_trl[23:0], b};
        // fold in one zero pad byte per trailer byte
        if (fr_pad != 2'd0) begin
          fr_crc = crc_next(fr_crc, 8'h00);
          fr_pad = fr_pad - 2'd1;
        end
        fr_pos = fr_pos + 16'd1;
        if (fr_pos >= 16'd4) begin
          res.status         = (fr_crc == fr_trl) ? ST_GOOD : ST_CRC_ERR;
          res.payload_length = fr_len;
          res.command        = fr_cmd;
          res.received_crc   = fr_trl;
          res.computed_crc   = fr_crc;
          fr_phase = RX_HUNT;
          fr_pos   = '0;
          fr_trl   = '0;
          fr_pad   = '0;
          return 1'b1;
        end
        return 1'b0;
      end
    endcase
  endfunction

  // Offer one byte after a random gap, hold it until accepted, then predict.
  // A typed row supplies its own expected status in place of the predictor's.
  task automatic send_byte(input logic [7:0] b, input bit typed, input result_t texp);
    int      gap;
    bit      due;
    result_t pred;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    due = rx_frame_predict(b, pred);
    if (due) begin
      pending_status.push_back(typed ? texp : pred);
    end
    sent_cnt++;
  endtask

  // Bytes that never match the start byte
  task automatic send_noise(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      if (b == cur_start) begin
        b = b ^ 8'h01;
      end
      send_byte(b, 1'b0, NO_RES);
    end
  endtask

  // One frame with random content: mostly well formed, sometimes over-long,
  // with a corrupted or random trailer, or cut off partway.
  task automatic send_frame(input bit at_limit);
    logic [15:0] lim;
    logic [15:0] len;
    logic [7:0]  cmd;
    logic [7:0]  b;
    logic [31:0] crc;
    logic [31:0] trl;
    int          kind;
    int          tkind;
    int          cut;
    int          npad;
    lim  = (cur_max_len < BUF_LEN_CAP) ? cur_max_len : BUF_LEN_CAP;
    kind = $urandom_range(0, 9);
    if (at_limit || (kind == 0 && lim <= 16'd40)) begin
      len = lim;
    end else if (kind == 1) begin
      len = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(lim + 1, 65535));
    end else begin
      len = 16'($urandom_range(0, (lim < 16'd12) ? lim : 12));
    end
    cmd   = 8'($urandom);
    tkind = $urandom_range(0, 9);
    cut   = (tkind == 9) ? $urandom_range(0, int'(len) + 3) : -1;

    crc = crc_next(CRC_SEED, cur_start);
    send_byte(cur_start, 1'b0, NO_RES);
    crc = crc_next(crc, len[15:8]);
    send_byte(len[15:8], 1'b0, NO_RES);
    crc = crc_next(crc, len[7:0]);
    send_byte(len[7:0], 1'b0, NO_RES);
    if (len > lim) begin
      return;
    end
    crc = crc_next(crc, cmd);
    send_byte(cmd, 1'b0, NO_RES);

    for (int i = 0; i < int'(len); i++) begin
      if (i == cut) begin
        return;
      end
      b   = ($urandom_range(0, 7) == 0) ? cur_start : 8'($urandom);
      crc = crc_next(crc, b);
      send_byte(b, 1'b0, NO_RES);
    end
    npad = (4 - int'(len) % 4) % 4;
    for (int k = 0; k < npad; k++) begin
      crc = crc_next(crc, 8'h00);
    end

    if (tkind < 7) begin
      trl = crc;
    end else if (tkind == 7) begin
      trl = crc ^ (32'h1 << $urandom_range(0, 31));
    end else begin
      trl = $urandom;
    end
    for (int j = 0; j < 4; j++) begin
      if (int'(len) + j == cut) begin
        return;
      end
      send_byte(trl[31 - 8 * j -: 8], 1'b0, NO_RES);
    end
  endtask

  // Random frames for one configuration; finish any cut-off frame so the
  // receiver ends up hunting before the next register write.
  task automatic run_phase(input int nbytes, input bit first_at_limit);
    int  start_cnt;
    bit  at_limit;
    start_cnt = sent_cnt;
    at_limit  = first_at_limit;
    while (sent_cnt - start_cnt < nbytes) begin
      if ($urandom_range(0, 3) == 0) begin
        send_noise($urandom_range(1, 3));
      end
      send_frame(at_limit);
      at_limit = 1'b0;
    end
    while (fr_phase != RX_HUNT) begin
      send_noise(1);
    end
  endtask

  // Drop valid, wait until every expected status is in, then let the
  // pipeline run empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes while idle; junk in the unused upper write bits for the
  // start byte.
  task automatic write_cfg(input bit set_start, input logic [7:0] sb,
                           input bit set_max, input logic [15:0] mp);
    if (set_start) begin
      cfg_we    <= 1'b1;
      cfg_index <= CfgStartByte;
      cfg_wdata <= {8'($urandom), sb};
      @(posedge clk);
      cur_start = sb;
    end
    if (set_max) begin
      cfg_we    <= 1'b1;
      cfg_index <= CfgMaxPayload;
      cfg_wdata <= mp;
      @(posedge clk);
      cur_max_len = mp;
    end
    cfg_we <= 1'b0;
  endtask

  task automatic chk_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  // Compare every status transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_status.size() == 0) begin
        $display("%0t: unexpected status transaction, expected none, actual tuser=%h tdata=%h",
                 $time, out_tuser, out_tdata);
        fail_cnt++;
      end else begin
        want_res = pending_status.pop_front();
        chk_field("status",         32'(want_res.status),         32'(out_tuser));
        chk_field("payload_length", 32'(want_res.payload_length), 32'(out_tdata[15:0]));
        chk_field("command",        32'(want_res.command),        32'(out_tdata[23:16]));
        chk_field("received_crc",   want_res.received_crc,        out_tdata[55:24]);
        chk_field("computed_crc",   want_res.computed_crc,        out_tdata[87:56]);
      end
    end
  end

  // Receiver: random ready gaps, no gaps in burst phases, and one long
  // hold-off on request so the output queue fills and in_tready drops.
  initial begin
    int w;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        w = rx_burst ? 0 : $urandom_range(0, 8);
        if (w > 0) begin
          out_tready <= 1'b0;
          repeat (w) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WATCHDOG_CYCLES) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed bytes under the reset configuration
    foreach (dir_tbl[i]) begin
      send_byte(dir_tbl[i].rx_byte, dir_tbl[i].typed, dir_tbl[i].exp_res);
    end
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        // zero limit: only empty payloads pass
        0: write_cfg(1'b1, 8'h00, 1'b1, 16'h0000);
        // top values; the buffer caps the length at 248
        1: write_cfg(1'b1, 8'hFF, 1'b1, 16'hFFFF);
        2: write_cfg(1'b0, 8'h00, 1'b1, 16'd3);
        // back to the reset start byte for the long hold-off
        3: begin
          write_cfg(1'b1, 8'h5F, 1'b1, 16'd8);
          hold_req = 1'b1;
        end
        4: write_cfg(1'b1, 8'($urandom), 1'b0, 16'h0000);
        5: write_cfg(1'b1, 8'($urandom), 1'b1, 16'd249);
        default: write_cfg(1'b1, 8'($urandom), 1'b1,
                           ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 300))
                                                       : 16'($urandom));
      endcase
      tx_burst = (p == 3) || (p % 3 == 2);
      rx_burst = (p % 4 == 1);
      run_phase(PHASE_BYTES, p == 1);
      settle();
    end

    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/sfr_pkg.sv
hdl/sfr_parser.sv
hdl/sfr_out_fifo.sv
hdl/sof_length_crc32_frame_receiver.sv
sim/sof_length_crc32_frame_receiver_tb.sv
